/* hw/rtl/tbrl_pkg.sv */
package tbrl_pkg;

    // configuration register width and counter width are fixed by the interface
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 32;
    localparam int PROD_W  = 2 * CFG_W;
    localparam int DIV_CW  = $clog2(CFG_W);
    localparam int IDX_W   = 1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RESET_MAX_TOKENS = 16'd10;
    localparam logic [CFG_W-1:0] RESET_WINDOW     = 16'd1;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MAX_TOKENS = 1'b0;
    localparam logic [IDX_W-1:0] CFG_WINDOW     = 1'b1;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_ADD,
        S_SPEND,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/token_bucket_rate_limiter_top.sv */
// Token bucket rate limiter.
//
// Input channel (in_valid/in_ready) carries one word per item: an operation
// (request or bucket reset) and a timestamp. Each word produces exactly one
// result word on the output channel (out_valid/out_ready): admit flag, tokens
// left, wait time and three saturating request counters.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// max_tokens (index 0) and window_length (index 1); it is always ready. The
// user must write it only while the block is idle, which it does not enforce.
//
// Steps: a request with partial refill goes from acceptance through
// evaluate/multiply, 16 restoring divider steps, add, spend and output load
// to out_valid. A request with full or no refill skips the divider and the
// add; a bucket reset also skips the spend. One item is in flight at a time
// and in_ready is high only while none is being worked on, so no new word is
// taken before the block is through with the last one.
// The output register holds a finished result while the receiver stalls, so
// the next word is accepted meanwhile; its result waits until the held one
// is taken. Reset empties the output, fills the bucket to 10 tokens, clears
// counters and the refill clock.
module token_bucket_rate_limiter_top #(
    parameter int TIME_BITS  = 32,
    parameter int TOKEN_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tbrl_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tbrl_pkg::CFG_W-1:0]   cfg_data,
    // input words
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [TIME_BITS-1:0]         now_time,
    // result words
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         allowed,
    output logic [tbrl_pkg::CFG_W-1:0]   tokens_left,
    output logic [tbrl_pkg::CFG_W-1:0]   wait_time,
    output logic [tbrl_pkg::CNT_W-1:0]   total_count,
    output logic [tbrl_pkg::CNT_W-1:0]   accepted_count,
    output logic [tbrl_pkg::CNT_W-1:0]   rejected_count
);
    import tbrl_pkg::*;

    // width that holds both a token count and a capacity register
    localparam int WIDE_W = (TOKEN_BITS > CFG_W) ? TOKEN_BITS : CFG_W;
    localparam int SUM_W  = WIDE_W + 1;

    // configuration registers
    logic [CFG_W-1:0]      max_reg, max_next;
    logic [CFG_W-1:0]      win_reg, win_next;

    // bucket state
    state_t                state_reg, state_next;
    logic [TOKEN_BITS-1:0] token_reg, token_next;
    logic [TIME_BITS-1:0]  last_reg, last_next;
    logic                  started_reg, started_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CNT_W-1:0]      admit_reg, admit_next;
    logic [CNT_W-1:0]      refuse_reg, refuse_next;

    // current word
    logic                  op_reg, op_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic                  ok_reg, ok_next;

    // divider: remainder and quotient/dividend shift register
    logic [CFG_W-1:0]      rem_reg, rem_next;
    logic [CFG_W-1:0]      quo_reg, quo_next;
    logic [DIV_CW-1:0]     step_reg, step_next;

    // output register
    logic                  ovalid_reg, ovalid_next;
    logic                  allowed_reg, allowed_next;
    logic [CFG_W-1:0]      tleft_reg, tleft_next;
    logic [CFG_W-1:0]      wait_reg, wait_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]      rej_reg, rej_next;

    logic                  in_fire;
    logic                  cfg_fire;
    logic [TIME_BITS-1:0]  diff;
    logic                  diff_neg;
    logic                  diff_ge_win;
    logic [TIME_BITS-1:0]  lag;
    logic [TOKEN_BITS-1:0] full;
    logic [WIDE_W-1:0]     max_wide;
    logic [WIDE_W-1:0]     cap_wide;
    logic [PROD_W-1:0]     product;
    logic [CFG_W:0]        div_shift;
    logic                  div_bit;
    logic [SUM_W-1:0]      sum;
    logic [CFG_W:0]        wait_sum;
    logic [CFG_W-1:0]      wait_calc;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;

    // full bucket: capacity saturated to the token counter width
    assign max_wide = WIDE_W'(max_reg);
    assign cap_wide = WIDE_W'({TOKEN_BITS{1'b1}});
    assign full     = TOKEN_BITS'((max_wide > cap_wide) ? cap_wide : max_wide);

    // signed elapsed time since last refill
    assign diff        = now_reg - last_reg;
    assign diff_neg    = diff[TIME_BITS-1];
    assign diff_ge_win = (diff >= TIME_BITS'(win_reg));
    assign lag         = '0 - diff;

    // 16x16 multiply; elapsed is below the window here, so it fits 16 bits
    assign product = PROD_W'(max_reg) * PROD_W'(diff[CFG_W-1:0]);

    // one restoring step: remainder always stays below the window
    assign div_shift = {rem_reg, quo_reg[CFG_W-1]};
    assign div_bit   = (div_shift >= {1'b0, win_reg});

    assign sum = SUM_W'(token_reg) + SUM_W'(quo_reg);

    // wait time, evaluated on the final state of the item
    assign wait_sum = {1'b0, win_reg} + {1'b0, lag[CFG_W-1:0]};
    always_comb
    begin
        if (token_reg != '0) begin
            wait_calc = '0;
        end else if (diff_neg) begin
            if (lag > TIME_BITS'({CFG_W{1'b1}}) || wait_sum[CFG_W])
                wait_calc = {CFG_W{1'b1}};
            else
                wait_calc = wait_sum[CFG_W-1:0];
        end else if (diff_ge_win) begin
            wait_calc = '0;
        end else begin
            wait_calc = win_reg - diff[CFG_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        max_next     = max_reg;
        win_next     = win_reg;
        token_next   = token_reg;
        last_next    = last_reg;
        started_next = started_reg;
        seen_next    = seen_reg;
        admit_next   = admit_reg;
        refuse_next  = refuse_reg;
        op_next      = op_reg;
        now_next     = now_reg;
        ok_next      = ok_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        ovalid_next  = ovalid_reg & ~out_ready;
        allowed_next = allowed_reg;
        tleft_next   = tleft_reg;
        wait_next    = wait_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        rej_next     = rej_reg;

        if (cfg_fire) begin
            case (cfg_index)
                CFG_MAX_TOKENS: max_next = cfg_data;
                CFG_WINDOW:     win_next = cfg_data;
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire) begin
                    op_next  = operation;
                    now_next = now_time;
                    if (!started_reg) begin
                        last_next    = now_time;
                        started_next = 1'b1;
                    end
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (op_reg == OP_RESET) begin
                    token_next = full;
                    last_next  = now_reg;
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end else begin
                    seen_next  = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
                    state_next = S_SPEND;
                    if (!diff_neg) begin
                        if (diff_ge_win) begin
                            token_next = full;
                            last_next  = now_reg;
                        end else if (diff != '0) begin
                            last_next  = now_reg;
                            rem_next   = product[PROD_W-1:CFG_W];
                            quo_next   = product[CFG_W-1:0];
                            step_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = div_bit ? CFG_W'(div_shift - {1'b0, win_reg})
                                    : div_shift[CFG_W-1:0];
                quo_next  = {quo_reg[CFG_W-2:0], div_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CW'(CFG_W - 1))
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                token_next = (sum > SUM_W'(full)) ? full : token_reg + TOKEN_BITS'(quo_reg);
                state_next = S_SPEND;
            end
            S_SPEND:
            begin
                if (token_reg != '0) begin
                    token_next = token_reg - 1'b1;
                    admit_next = (admit_reg == '1) ? admit_reg : admit_reg + 1'b1;
                    ok_next    = 1'b1;
                end else begin
                    refuse_next = (refuse_reg == '1) ? refuse_reg : refuse_reg + 1'b1;
                    ok_next     = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // load only once the previous word has left
                if (!ovalid_reg || out_ready) begin
                    ovalid_next  = 1'b1;
                    allowed_next = ok_reg;
                    tleft_next   = CFG_W'(token_reg);
                    wait_next    = wait_calc;
                    total_next   = seen_reg;
                    acc_next     = admit_reg;
                    rej_next     = refuse_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            max_reg     <= RESET_MAX_TOKENS;
            win_reg     <= RESET_WINDOW;
            token_reg   <= TOKEN_BITS'(RESET_MAX_TOKENS);
            last_reg    <= '0;
            started_reg <= 1'b0;
            seen_reg    <= '0;
            admit_reg   <= '0;
            refuse_reg  <= '0;
            ovalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            max_reg     <= max_next;
            win_reg     <= win_next;
            token_reg   <= token_next;
            last_reg    <= last_next;
            started_reg <= started_next;
            seen_reg    <= seen_next;
            admit_reg   <= admit_next;
            refuse_reg  <= refuse_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        now_reg     <= now_next;
        ok_reg      <= ok_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        allowed_reg <= allowed_next;
        tleft_reg   <= tleft_next;
        wait_reg    <= wait_next;
        total_reg   <= total_next;
        acc_reg     <= acc_next;
        rej_reg     <= rej_next;
    end

    assign out_valid      = ovalid_reg;
    assign allowed        = allowed_reg;
    assign tokens_left    = tleft_reg;
    assign wait_time      = wait_reg;
    assign total_count    = total_reg;
    assign accepted_count = acc_reg;
    assign rejected_count = rej_reg;

    // an accepted word always goes straight to evaluation
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EVAL))
        else $error("accepted word did not enter evaluation");

    // restoring divider invariant: remainder below the window
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < win_reg))
        else $error("divider remainder not below window");

    // an admitted word is counted
    a_admit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && allowed) |-> (accepted_count != '0))
        else $error("admitted word with zero admit count");

    // a request only leaves the spend step with a result pending
    a_spend_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPEND) |=> (state_reg == S_DONE))
        else $error("spend step did not go to output");

endmodule

/* sim/token_bucket_rate_limiter_top_test.sv */
`timescale 1ns / 100ps

module token_bucket_rate_limiter_top_test;
    import tbrl_pkg::*;

    // One result word as the block should present it.
    typedef struct {
        logic        allowed;
        logic [15:0] tokens_left;
        logic [15:0] wait_time;
        logic [31:0] total_count;
        logic [31:0] accepted_count;
        logic [31:0] rejected_count;
    } verdict_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index      = CFG_MAX_TOKENS;
    logic [CFG_W-1:0]  cfg_data       = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              operation      = OP_REQUEST;
    logic [31:0]       now_time       = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic              allowed;
    logic [CFG_W-1:0]  tokens_left;
    logic [CFG_W-1:0]  wait_time;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  accepted_count;
    logic [CNT_W-1:0]  rejected_count;

    // Bucket predictor: its own copy of the registers and the bucket state.
    logic [15:0] cap_reg       = RESET_MAX_TOKENS;
    logic [15:0] win_reg       = RESET_WINDOW;
    logic [15:0] bucket_tokens = RESET_MAX_TOKENS;
    logic [31:0] refill_stamp  = '0;
    logic        stamp_valid   = 1'b0;
    logic [31:0] seen_cnt      = '0;
    logic [31:0] admit_cnt     = '0;
    logic [31:0] refuse_cnt    = '0;

    // Results predicted for accepted words, oldest first.
    verdict_t    pending_verdicts[$];
    verdict_t    oldest;
    int unsigned fail_count = 0;

    // Timestamp cursor for the random traffic and the receiver stall pattern.
    logic [31:0] clock_now = 32'd5000;
    int unsigned rx_mode   = 0;
    logic [31:0] rx_tick   = '0;

    token_bucket_rate_limiter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .now_time       (now_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .allowed        (allowed),
        .tokens_left    (tokens_left),
        .wait_time      (wait_time),
        .total_count    (total_count),
        .accepted_count (accepted_count),
        .rejected_count (rejected_count)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // Time still to wait for a token; nonzero only with an empty bucket.
    function automatic logic [15:0] wait_for_token(logic [31:0] t);
        logic [31:0] diff;
        logic [31:0] lag;
        logic [16:0] total;
        diff = t - refill_stamp;
        if (bucket_tokens != 0)
            return 16'd0;
        if (diff[31])
        begin
            // clock went backwards: window plus the lag, saturated
            lag = -diff;
            if (lag > 32'h0000_FFFF)
                return 16'hFFFF;
            total = {1'b0, win_reg} + {1'b0, lag[15:0]};
            return total[16] ? 16'hFFFF : total[15:0];
        end
        if (diff >= {16'd0, win_reg})
            return 16'd0;
        return win_reg - diff[15:0];
    endfunction

    // Applies one word to the predicted bucket and returns its result.
    function automatic verdict_t bucket_step(logic op, logic [31:0] t);
        verdict_t    v;
        logic [31:0] diff;
        logic [63:0] cap64;
        logic [63:0] win64;
        logic [63:0] gain;
        logic [63:0] filled;
        if (!stamp_valid)
        begin
            // first word after reset only starts the refill clock
            refill_stamp = t;
            stamp_valid  = 1'b1;
        end
        v.allowed = 1'b0;
        if (op == OP_REQUEST)
        begin
            diff = t - refill_stamp;
            if (!diff[31])
            begin
                if (diff >= {16'd0, win_reg})
                begin
                    bucket_tokens = cap_reg;
                    refill_stamp  = t;
                end
                else if (diff != 0)
                begin
                    // partial credit, truncated; the remainder is dropped
                    cap64  = {48'd0, cap_reg};
                    win64  = {48'd0, win_reg};
                    gain   = (cap64 * {32'd0, diff}) / win64;
                    filled = {48'd0, bucket_tokens} + gain;
                    bucket_tokens = (filled > cap64) ? cap_reg : filled[15:0];
                    refill_stamp  = t;
                end
            end
            seen_cnt = sat_inc(seen_cnt);
            if (bucket_tokens != 0)
            begin
                bucket_tokens = bucket_tokens - 16'd1;
                admit_cnt     = sat_inc(admit_cnt);
                v.allowed     = 1'b1;
            end
            else
                refuse_cnt = sat_inc(refuse_cnt);
        end
        else
        begin
            bucket_tokens = cap_reg;
            refill_stamp  = t;
        end
        v.tokens_left    = bucket_tokens;
        v.wait_time      = wait_for_token(t);
        v.total_count    = seen_cnt;
        v.accepted_count = admit_cnt;
        v.rejected_count = refuse_cnt;
        return v;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Result checker: every word taken from the output is matched against
    // the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 40)
                    $display("%0t: unexpected result word, expected none, actual tokens %0d",
                             $time, tokens_left);
            end
            else
            begin
                oldest = pending_verdicts.pop_front();
                check_field("allowed", 32'(oldest.allowed), 32'(allowed));
                check_field("tokens_left", 32'(oldest.tokens_left), 32'(tokens_left));
                check_field("wait_time", 32'(oldest.wait_time), 32'(wait_time));
                check_field("total_count", oldest.total_count, total_count);
                check_field("accepted_count", oldest.accepted_count, accepted_count);
                check_field("rejected_count", oldest.rejected_count, rejected_count);
            end
        end
    end

    // Receiver: picks a new mode whenever the low byte of its tick counter is zero,
    // among always ready, mostly ready, mostly stalled and a periodic window of ready cycles.
    always @(posedge clk)
    begin
        if (rx_tick[7:0] == 8'd0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_tick[4:0] < 5'd6);
        endcase
        rx_tick = rx_tick + 32'd1;
    end

    // Sends one word and predicts its result on acceptance. Valid is left
    // high so a following word goes out back to back.
    task automatic send_word(input logic op, input logic [31:0] t);
        in_valid  <= 1'b1;
        operation <= op;
        now_time  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_verdicts.push_back(bucket_step(op, t));
    endtask

    task automatic idle_gap(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Holds the sender until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Writes both registers; only called with the block idle.
    task automatic configure(input logic [15:0] cap, input logic [15:0] win);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_TOKENS;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = cap;
        cfg_index <= CFG_WINDOW;
        cfg_data  <= win;
        do
            @(posedge clk);
        while (!cfg_ready);
        win_reg = win;
        cfg_valid <= 1'b0;
    endtask

    // Next random timestamp, mostly close to the window so the bucket
    // drains and partially refills; sometimes backwards, wrapping or far off.
    function automatic logic [31:0] next_stamp();
        int unsigned pick;
        int unsigned w;
        pick = $urandom_range(0, 19);
        w    = {16'd0, win_reg};
        if (pick < 7)
            ;
        else if (pick < 13)
            clock_now = clock_now + $urandom_range(1, w);
        else if (pick < 15)
            clock_now = clock_now + $urandom_range(w, 3 * w);
        else if (pick == 15)
            clock_now = clock_now - $urandom_range(1, w + 3);
        else if (pick == 16)
            clock_now = clock_now - $urandom_range(65536, 200000);
        else if (pick == 17)
            clock_now = $urandom;
        else if (pick == 18)
            clock_now = 32'hFFFF_FFFF - $urandom_range(0, w);
        else
            clock_now = clock_now + $urandom_range(1, 3);
        return clock_now;
    endfunction

    // Reset values: first word only starts the clock, then drain to empty.
    task automatic test_first_request();
        repeat (11) send_word(OP_REQUEST, 32'd1000);
    endtask

    // Clock running backwards, a lag beyond 16 bits, full refill,
    // bucket reset at the top of the range and a wrap to zero.
    task automatic test_time_edges();
        send_word(OP_REQUEST, 32'd999);
        send_word(OP_REQUEST, 32'd1000 - 32'd70000);
        send_word(OP_REQUEST, 32'd1001);
        send_word(OP_RESET, 32'hFFFF_FFFF);
        send_word(OP_REQUEST, 32'd0);
    endtask

    // Capacity lowered under a fuller bucket, then partial refill capped.
    task automatic test_capacity_change();
        drain();
        configure(16'd3, 16'd100);
        send_word(OP_REQUEST, 32'd0);
        send_word(OP_REQUEST, 32'd40);
        repeat (3) send_word(OP_REQUEST, 32'd40);
    endtask

    // Register extremes and credit lost to truncation.
    task automatic test_extremes();
        drain();
        configure(16'hFFFF, 16'hFFFF);
        send_word(OP_RESET, 32'd5);
        send_word(OP_REQUEST, 32'd5);
        drain();
        configure(16'd1, 16'hFFFF);
        send_word(OP_RESET, 32'd0);
        send_word(OP_REQUEST, 32'd0);
        send_word(OP_REQUEST, 32'd1);
        drain();
        configure(16'hFFFF, 16'd1);
        send_word(OP_REQUEST, 32'd1);
    endtask

    // Random traffic in phases, each with its own register setting.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        logic        calm;
        logic [15:0] cap;
        logic [15:0] win;
        logic        op;
        for (phase = 0; phase < 13; phase++)
        begin
            drain();
            case (phase)
                0: begin cap = 16'd1;     win = 16'd1;     end
                1: begin cap = 16'hFFFF;  win = 16'hFFFF;  end
                2: begin cap = 16'd1;     win = 16'hFFFF;  end
                3: begin cap = 16'hFFFF;  win = 16'd1;     end
                default:
                begin
                    cap = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 12));
                    case ($urandom_range(0, 3))
                        0: win = 16'd1;
                        1: win = 16'($urandom_range(2, 60));
                        2: win = 16'($urandom_range(1, 65535));
                        default: win = 16'hFFFF;
                    endcase
                end
            endcase
            configure(cap, win);
            calm = ($urandom_range(0, 3) == 0);
            left = 125;
            while (left > 0)
            begin
                burst = $urandom_range(1, 12);
                while (burst > 0 && left > 0)
                begin
                    op = ($urandom_range(0, 11) == 0) ? OP_RESET : OP_REQUEST;
                    send_word(op, next_stamp());
                    burst--;
                    left--;
                end
                if ($urandom_range(0, 39) == 0)
                    drain();
                else
                begin
                    if (calm)
                        gap = 0;
                    else if ($urandom_range(0, 3) == 0)
                        gap = $urandom_range(5, 25);
                    else
                        gap = $urandom_range(0, 4);
                    idle_gap(gap);
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_request();
        test_time_edges();
        test_capacity_change();
        test_extremes();
        test_random_traffic();
        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("** token_bucket_rate_limiter_top: PASSED **");
        else
            $display("** token_bucket_rate_limiter_top: FAILED **");
        $finish;
    end

    // Watchdog, many times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("** token_bucket_rate_limiter_top: FAILED **");
        $finish;
    end

endmodule
